### design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int IDX_W   = 3;
   localparam int TEMP_W  = 15;
   localparam int PRESS_W = 17;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_SENS_C1        = 3'd0;
   localparam logic [IDX_W-1:0] CSR_OFFSET_C2      = 3'd1;
   localparam logic [IDX_W-1:0] CSR_SENS_TEMPCO_C3 = 3'd2;
   localparam logic [IDX_W-1:0] CSR_OFF_TEMPCO_C4  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_REF_TEMP_C5    = 3'd4;
   localparam logic [IDX_W-1:0] CSR_TEMP_COEFF_C6  = 3'd5;

   localparam int TEMP_BASE  = 2000;
   localparam int COLD_SHIFT = 3500;
   localparam int TEMP_MIN   = -4000;
   localparam int TEMP_MAX   = 8500;
   localparam int PRESS_MIN  = 1000;
   localparam int PRESS_MAX  = 120000;

   localparam int SH_TEMP  = 23;
   localparam int SH_OFF   = 7;
   localparam int SH_SENS  = 8;
   localparam int SH_T2    = 31;
   localparam int SH_PROD  = 21;
   localparam int SH_PRESS = 15;

   typedef struct packed {
      logic [CAL_W-1:0] sensitivity_c1;
      logic [CAL_W-1:0] offset_c2;
      logic [CAL_W-1:0] sens_tempco_c3;
      logic [CAL_W-1:0] offset_tempco_c4;
      logic [CAL_W-1:0] reference_temp_c5;
      logic [CAL_W-1:0] temp_coeff_c6;
   } cal_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_centideg;
      logic [PRESS_W-1:0]       press_centimbar;
      logic                     clamped;
   } result_type;

   // signed division by 2^k, rounded toward zero
   function automatic logic signed [63:0] trunc_div_pow2(input logic signed [63:0] x,
                                                         input int unsigned k);
      logic [63:0]        mask;
      logic signed [63:0] q;
      mask = (64'd1 << k) - 64'd1;
      q = x >>> k;
      if (x[63] && (($unsigned(x) & mask) != 64'd0)) begin
         q = q + 64'sd1;
      end
      return q;
   endfunction

endpackage

### design/bsc_req_if.sv
// ----------------------------------------------------------------------------
// bsc_req_if
// Raw conversion channel: pressure and temperature words with valid/ready.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   logic                        valid;
   logic                        ready;
   logic [bsc_pkg::RAW_W-1:0]   raw_press;
   logic [bsc_pkg::RAW_W-1:0]   raw_temp;

   modport source (output valid, output raw_press, output raw_temp, input ready);
   modport sink   (input valid, input raw_press, input raw_temp, output ready);
endinterface

### design/bsc_rsp_if.sv
// ----------------------------------------------------------------------------
// bsc_rsp_if
// Compensated result channel: temperature, pressure and clamp flag.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bsc_pkg::TEMP_W-1:0]  temp_centideg;
   logic [bsc_pkg::PRESS_W-1:0]        press_centimbar;
   logic                               clamped;

   modport source (output valid, output temp_centideg, output press_centimbar,
                   output clamped, input ready);
   modport sink   (input valid, input temp_centideg, input press_centimbar,
                   input clamped, output ready);
endinterface

### design/bsc_pipe.sv
// ----------------------------------------------------------------------------
// bsc_pipe
// Ten-stage compensation datapath; all stages advance together on advance.
// ----------------------------------------------------------------------------
module bsc_pipe (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic [bsc_pkg::RAW_W-1:0]      raw_press,
   input  logic [bsc_pkg::RAW_W-1:0]      raw_temp,
   input  bsc_pkg::cal_type               cal,
   output logic                           out_valid,
   output bsc_pkg::result_type            out_result
);

   localparam int NSTAGE = 10;

   logic [NSTAGE-1:0] vld_ff;

   // stage 1
   logic [23:0]        d1_s1_ff;
   logic signed [24:0] dt_s1_ff, dt_s1_in;
   // stage 2
   logic [23:0]        d1_s2_ff;
   logic signed [41:0] pt_s2_ff, pt_s2_in;
   logic signed [41:0] poff_s2_ff, poff_s2_in;
   logic signed [41:0] psens_s2_ff, psens_s2_in;
   logic signed [49:0] pdd_s2_ff, pdd_s2_in;
   // stage 3
   logic [23:0]        d1_s3_ff;
   logic signed [17:0] q_s3_ff, q_s3_in;
   logic signed [34:0] offv_s3_ff, offv_s3_in;
   logic signed [33:0] sensv_s3_ff, sensv_s3_in;
   logic [16:0]        tfix_s3_ff, tfix_s3_in;
   logic signed [63:0] pt_q, poff_q, psens_q;
   // stage 4
   logic [23:0]        d1_s4_ff;
   logic signed [17:0] q_s4_ff;
   logic signed [34:0] offv_s4_ff;
   logic signed [33:0] sensv_s4_ff;
   logic [16:0]        tfix_s4_ff;
   logic [33:0]        sq1_s4_ff, sq1_s4_in;
   logic [34:0]        sq2_s4_ff, sq2_s4_in;
   logic               low_s4_ff, cold_s4_ff, cold_s4_in;
   logic signed [18:0] v_s4;
   // stage 5
   logic [23:0]        d1_s5_ff;
   logic signed [34:0] offv_s5_ff;
   logic signed [33:0] sensv_s5_ff;
   logic [38:0]        offfix_s5_ff, offfix_s5_in;
   logic [37:0]        sensfix_s5_ff, sensfix_s5_in;
   logic signed [19:0] temp_s5_ff, temp_s5_in;
   logic signed [18:0] t1_s5;
   // stage 6
   logic [23:0]        d1_s6_ff;
   logic signed [39:0] off_s6_ff, off_s6_in;
   logic signed [39:0] sens_s6_ff, sens_s6_in;
   logic signed [14:0] temp_s6_ff, temp_s6_in;
   logic               thit_s6_ff, thit_s6_in;
   // stage 7
   logic signed [39:0] off_s7_ff;
   logic signed [14:0] temp_s7_ff;
   logic               thit_s7_ff;
   logic [43:0]        plo_s7_ff, plo_s7_in;
   logic signed [44:0] phi_s7_ff, phi_s7_in;
   // stage 8
   logic signed [39:0] off_s8_ff;
   logic signed [14:0] temp_s8_ff;
   logic               thit_s8_ff;
   logic signed [63:0] prod_s8_ff, prod_s8_in;
   // stage 9
   logic signed [14:0] temp_s9_ff;
   logic               thit_s9_ff;
   logic signed [42:0] diffp_s9_ff, diffp_s9_in;
   logic signed [63:0] prod_q;
   // stage 10
   bsc_pkg::result_type res_s10_ff, res_s10_in;
   logic signed [63:0]  press_q;
   logic                phit;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], in_valid};
      end
   end

   // stage 1: dt
   always_comb begin
      dt_s1_in = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.reference_temp_c5, 8'h00});
   end

   // stage 2: products of dt
   always_comb begin
      pt_s2_in    = 42'(dt_s1_ff * $signed({1'b0, cal.temp_coeff_c6}));
      poff_s2_in  = 42'(dt_s1_ff * $signed({1'b0, cal.offset_tempco_c4}));
      psens_s2_in = 42'(dt_s1_ff * $signed({1'b0, cal.sens_tempco_c3}));
      pdd_s2_in   = 50'(dt_s1_ff * dt_s1_ff);
   end

   // stage 3: first-order terms
   always_comb begin
      pt_q        = bsc_pkg::trunc_div_pow2(64'(pt_s2_ff), bsc_pkg::SH_TEMP);
      poff_q      = bsc_pkg::trunc_div_pow2(64'(poff_s2_ff), bsc_pkg::SH_OFF);
      psens_q     = bsc_pkg::trunc_div_pow2(64'(psens_s2_ff), bsc_pkg::SH_SENS);
      q_s3_in     = 18'(pt_q);
      offv_s3_in  = 35'($signed({1'b0, cal.offset_c2, 16'h0000})) + 35'(poff_q);
      sensv_s3_in = 34'($signed({1'b0, cal.sensitivity_c1, 15'h0000})) + 34'(psens_q);
      tfix_s3_in  = pdd_s2_ff[47:31];
   end

   // stage 4: squares
   always_comb begin
      v_s4       = 19'(q_s3_ff) + 19'(bsc_pkg::COLD_SHIFT);
      cold_s4_in = v_s4[18];
      sq1_s4_in  = 34'(q_s3_ff * q_s3_ff);
      sq2_s4_in  = 35'(v_s4 * v_s4);
   end

   // stage 5: second-order corrections
   always_comb begin
      offfix_s5_in  = '0;
      sensfix_s5_in = '0;
      t1_s5         = 19'(q_s4_ff) + 19'(bsc_pkg::TEMP_BASE);
      temp_s5_in    = 20'(t1_s5);
      if (low_s4_ff) begin
         offfix_s5_in  = 39'((39'(sq1_s4_ff) * 39'd5) >> 1);
         sensfix_s5_in = 38'((38'(sq1_s4_ff) * 38'd5) >> 2);
         temp_s5_in    = 20'(t1_s5) - $signed({3'b000, tfix_s4_ff});
         if (cold_s4_ff) begin
            offfix_s5_in  = offfix_s5_in + 39'(39'(sq2_s4_ff) * 39'd7);
            sensfix_s5_in = sensfix_s5_in + 38'((38'(sq2_s4_ff) * 38'd11) >> 1);
         end
      end
   end

   // stage 6: corrected offset and sensitivity, temperature clamp
   always_comb begin
      off_s6_in  = 40'(offv_s5_ff) - $signed({1'b0, offfix_s5_ff});
      sens_s6_in = 40'(sensv_s5_ff) - $signed({2'b00, sensfix_s5_ff});
      thit_s6_in = 1'b0;
      temp_s6_in = 15'(temp_s5_ff);
      if (temp_s5_ff < bsc_pkg::TEMP_MIN) begin
         temp_s6_in = 15'(bsc_pkg::TEMP_MIN);
         thit_s6_in = 1'b1;
      end else if (temp_s5_ff > bsc_pkg::TEMP_MAX) begin
         temp_s6_in = 15'(bsc_pkg::TEMP_MAX);
         thit_s6_in = 1'b1;
      end
   end

   // stage 7: split pressure product
   always_comb begin
      plo_s7_in = d1_s6_ff * sens_s6_ff[19:0];
      phi_s7_in = 45'($signed({1'b0, d1_s6_ff}) * $signed(sens_s6_ff[39:20]));
   end

   // stage 8: recombine
   always_comb begin
      prod_s8_in = (64'(phi_s7_ff) <<< 20) + $signed({20'd0, plo_s7_ff});
   end

   // stage 9: scale and remove offset
   always_comb begin
      prod_q      = bsc_pkg::trunc_div_pow2(prod_s8_ff, bsc_pkg::SH_PROD);
      diffp_s9_in = 43'(prod_q) - 43'(off_s8_ff);
   end

   // stage 10: final scale and pressure clamp
   always_comb begin
      press_q = bsc_pkg::trunc_div_pow2(64'(diffp_s9_ff), bsc_pkg::SH_PRESS);
      phit    = 1'b0;
      res_s10_in.temp_centideg   = temp_s9_ff;
      res_s10_in.press_centimbar = 17'(press_q);
      if (press_q < bsc_pkg::PRESS_MIN) begin
         res_s10_in.press_centimbar = 17'(bsc_pkg::PRESS_MIN);
         phit = 1'b1;
      end else if (press_q > bsc_pkg::PRESS_MAX) begin
         res_s10_in.press_centimbar = 17'(bsc_pkg::PRESS_MAX);
         phit = 1'b1;
      end
      res_s10_in.clamped = phit | thit_s9_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d1_s1_ff    <= raw_press;
         dt_s1_ff    <= dt_s1_in;

         d1_s2_ff    <= d1_s1_ff;
         pt_s2_ff    <= pt_s2_in;
         poff_s2_ff  <= poff_s2_in;
         psens_s2_ff <= psens_s2_in;
         pdd_s2_ff   <= pdd_s2_in;

         d1_s3_ff    <= d1_s2_ff;
         q_s3_ff     <= q_s3_in;
         offv_s3_ff  <= offv_s3_in;
         sensv_s3_ff <= sensv_s3_in;
         tfix_s3_ff  <= tfix_s3_in;

         d1_s4_ff    <= d1_s3_ff;
         q_s4_ff     <= q_s3_ff;
         offv_s4_ff  <= offv_s3_ff;
         sensv_s4_ff <= sensv_s3_ff;
         tfix_s4_ff  <= tfix_s3_ff;
         sq1_s4_ff   <= sq1_s4_in;
         sq2_s4_ff   <= sq2_s4_in;
         low_s4_ff   <= q_s3_ff[17];
         cold_s4_ff  <= cold_s4_in;

         d1_s5_ff      <= d1_s4_ff;
         offv_s5_ff    <= offv_s4_ff;
         sensv_s5_ff   <= sensv_s4_ff;
         offfix_s5_ff  <= offfix_s5_in;
         sensfix_s5_ff <= sensfix_s5_in;
         temp_s5_ff    <= temp_s5_in;

         d1_s6_ff    <= d1_s5_ff;
         off_s6_ff   <= off_s6_in;
         sens_s6_ff  <= sens_s6_in;
         temp_s6_ff  <= temp_s6_in;
         thit_s6_ff  <= thit_s6_in;

         off_s7_ff   <= off_s6_ff;
         temp_s7_ff  <= temp_s6_ff;
         thit_s7_ff  <= thit_s6_ff;
         plo_s7_ff   <= plo_s7_in;
         phi_s7_ff   <= phi_s7_in;

         off_s8_ff   <= off_s7_ff;
         temp_s8_ff  <= temp_s7_ff;
         thit_s8_ff  <= thit_s7_ff;
         prod_s8_ff  <= prod_s8_in;

         temp_s9_ff  <= temp_s8_ff;
         thit_s9_ff  <= thit_s8_ff;
         diffp_s9_ff <= diffp_s9_in;

         res_s10_ff  <= res_s10_in;
      end
   end

   assign out_valid  = vld_ff[NSTAGE-1];
   assign out_result = res_s10_ff;

endmodule

### design/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order compensation of raw pressure/temperature conversions.
// ----------------------------------------------------------------------------
// depth: ten-stage pipeline from request transaction to response transaction
// throughput: one transaction per cycle absent backpressure; multipliers set the depth
// backpressure: every stage holds while the response is valid and not taken
// reset: clears all stage valid bits and the six calibration registers to zero
module baro_sensor_compensation (
   input  logic                          clock,
   input  logic                          reset,
   bsc_req_if.sink                       req_if,
   bsc_rsp_if.source                     rsp_if,
   input  logic                          csr_write_en,
   input  logic [bsc_pkg::IDX_W-1:0]     csr_index,
   input  logic [bsc_pkg::CAL_W-1:0]     csr_wdata
);

   bsc_pkg::cal_type    cal_ff;
   bsc_pkg::result_type result;
   logic                advance;
   logic                out_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            bsc_pkg::CSR_SENS_C1:        cal_ff.sensitivity_c1    <= csr_wdata;
            bsc_pkg::CSR_OFFSET_C2:      cal_ff.offset_c2         <= csr_wdata;
            bsc_pkg::CSR_SENS_TEMPCO_C3: cal_ff.sens_tempco_c3    <= csr_wdata;
            bsc_pkg::CSR_OFF_TEMPCO_C4:  cal_ff.offset_tempco_c4  <= csr_wdata;
            bsc_pkg::CSR_REF_TEMP_C5:    cal_ff.reference_temp_c5 <= csr_wdata;
            bsc_pkg::CSR_TEMP_COEFF_C6:  cal_ff.temp_coeff_c6     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign advance      = ~out_valid | rsp_if.ready;
   assign req_if.ready = advance;

   bsc_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_if.valid),
      .raw_press  (req_if.raw_press),
      .raw_temp   (req_if.raw_temp),
      .cal        (cal_ff),
      .out_valid  (out_valid),
      .out_result (result)
   );

   assign rsp_if.valid           = out_valid;
   assign rsp_if.temp_centideg   = result.temp_centideg;
   assign rsp_if.press_centimbar = result.press_centimbar;
   assign rsp_if.clamped         = result.clamped;

   // results always inside the sensor range
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.temp_centideg >= bsc_pkg::TEMP_MIN) &&
                       (rsp_if.temp_centideg <= bsc_pkg::TEMP_MAX) &&
                       (rsp_if.press_centimbar >= bsc_pkg::PRESS_MIN) &&
                       (rsp_if.press_centimbar <= bsc_pkg::PRESS_MAX))
      else $error("result outside sensor range");

   // no response right after reset
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid right after reset");

   // an unflagged result is never below the lower temperature or pressure limit
   a_clamp_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.clamped) |->
         (rsp_if.temp_centideg >= bsc_pkg::TEMP_MIN) &&
         (rsp_if.press_centimbar >= bsc_pkg::PRESS_MIN))
      else $error("clamp flag inconsistent with result");

endmodule

### sim/baro_sensor_compensation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_test
// Self-checking bench for the pressure/temperature compensation pipeline.
// Directed corner conversions and random conversions run under several sets of
// calibration words, with random gaps on the request side and random stalls
// on the response side. An in-bench integer predictor computes each expected
// response, and a scoreboard compares responses in order, field by field.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_test;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 4;
   localparam int RANDOM_PHASES   = 9;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DRAIN_CYCLES    = 20;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int REPORT_LIMIT    = 10;

   typedef logic [bsc_pkg::CAL_W-1:0] cal_word_type;
   typedef logic [bsc_pkg::RAW_W-1:0] raw_word_type;

   localparam logic [bsc_pkg::IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [bsc_pkg::IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam raw_word_type RAW_MAX  = 24'hFFFFFF;
   localparam raw_word_type DS_PRESS = 24'd9085466;
   localparam raw_word_type DS_TEMP  = 24'd8569150;

   localparam bsc_pkg::cal_type CAL_TYPICAL = '{16'd40127, 16'd36924, 16'd23317,
                                               16'd23282, 16'd33464, 16'd28312};
   localparam bsc_pkg::cal_type CAL_ZERO    = '0;
   localparam bsc_pkg::cal_type CAL_ONES    = '1;

   typedef struct packed {
      bsc_pkg::result_type want;
      raw_word_type        raw_press;
      raw_word_type        raw_temp;
   } expected_type;

   class compensation_scoreboard;
      bsc_pkg::cal_type cal;
      expected_type     pending_q[$];
      int unsigned      errors;

      function new();
         cal = '0;
         errors = 0;
      endfunction

      function void note_write(logic [bsc_pkg::IDX_W-1:0] idx, cal_word_type value);
         case (idx)
            bsc_pkg::CSR_SENS_C1:        cal.sensitivity_c1 = value;
            bsc_pkg::CSR_OFFSET_C2:      cal.offset_c2 = value;
            bsc_pkg::CSR_SENS_TEMPCO_C3: cal.sens_tempco_c3 = value;
            bsc_pkg::CSR_OFF_TEMPCO_C4:  cal.offset_tempco_c4 = value;
            bsc_pkg::CSR_REF_TEMP_C5:    cal.reference_temp_c5 = value;
            bsc_pkg::CSR_TEMP_COEFF_C6:  cal.temp_coeff_c6 = value;
            default: ;
         endcase
      endfunction

      function bsc_pkg::result_type compensate(raw_word_type press_raw,
                                               raw_word_type temp_raw);
         longint              d1, d2, dt, t1, t2, off, sens, off2, sens2, sq, temp, press;
         bit                  hit;
         bsc_pkg::result_type r;
         d1 = longint'(press_raw);
         d2 = longint'(temp_raw);
         dt = d2 - longint'(cal.reference_temp_c5) * 256;
         t1 = bsc_pkg::TEMP_BASE
              + dt * longint'(cal.temp_coeff_c6) / (longint'(1) << bsc_pkg::SH_TEMP);
         off = (longint'(cal.offset_c2) << 16)
               + longint'(cal.offset_tempco_c4) * dt / (longint'(1) << bsc_pkg::SH_OFF);
         sens = (longint'(cal.sensitivity_c1) << 15)
                + longint'(cal.sens_tempco_c3) * dt / (longint'(1) << bsc_pkg::SH_SENS);
         t2 = 0;
         off2 = 0;
         sens2 = 0;
         // second-order terms below 20 degC, extra terms below -15 degC
         if (t1 < bsc_pkg::TEMP_BASE) begin
            t2 = dt * dt / (longint'(1) << bsc_pkg::SH_T2);
            sq = (t1 - bsc_pkg::TEMP_BASE) * (t1 - bsc_pkg::TEMP_BASE);
            off2 = 5 * sq / 2;
            sens2 = 5 * sq / 4;
            if (t1 < bsc_pkg::TEMP_BASE - bsc_pkg::COLD_SHIFT) begin
               sq = (t1 + bsc_pkg::COLD_SHIFT - bsc_pkg::TEMP_BASE)
                    * (t1 + bsc_pkg::COLD_SHIFT - bsc_pkg::TEMP_BASE);
               off2 = off2 + 7 * sq;
               sens2 = sens2 + 11 * sq / 2;
            end
         end
         temp = t1 - t2;
         press = ((d1 * (sens - sens2)) / (longint'(1) << bsc_pkg::SH_PROD) - (off - off2))
                 / (longint'(1) << bsc_pkg::SH_PRESS);
         hit = 1'b0;
         if (temp < bsc_pkg::TEMP_MIN) begin
            temp = bsc_pkg::TEMP_MIN;
            hit = 1'b1;
         end else if (temp > bsc_pkg::TEMP_MAX) begin
            temp = bsc_pkg::TEMP_MAX;
            hit = 1'b1;
         end
         if (press < bsc_pkg::PRESS_MIN) begin
            press = bsc_pkg::PRESS_MIN;
            hit = 1'b1;
         end else if (press > bsc_pkg::PRESS_MAX) begin
            press = bsc_pkg::PRESS_MAX;
            hit = 1'b1;
         end
         r.temp_centideg = temp[bsc_pkg::TEMP_W-1:0];
         r.press_centimbar = press[bsc_pkg::PRESS_W-1:0];
         r.clamped = hit;
         return r;
      endfunction

      function void note_request(raw_word_type press_raw, raw_word_type temp_raw);
         expected_type e;
         e.want = compensate(press_raw, temp_raw);
         e.raw_press = press_raw;
         e.raw_temp = temp_raw;
         pending_q.push_back(e);
      endfunction

      function void check_response(bsc_pkg::result_type got);
         expected_type e;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected response transaction: temp %0d press %0d clamped %0b",
                        got.temp_centideg, got.press_centimbar, got.clamped);
         end else begin
            e = pending_q.pop_front();
            if (got.temp_centideg !== e.want.temp_centideg ||
                got.press_centimbar !== e.want.press_centimbar ||
                got.clamped !== e.want.clamped) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("mismatch for raw_press %0d raw_temp %0d: expected temp %0d",
                           e.raw_press, e.raw_temp, e.want.temp_centideg);
                  $display("   press %0d clamped %0b, got temp %0d press %0d clamped %0b",
                           e.want.press_centimbar, e.want.clamped, got.temp_centideg,
                           got.press_centimbar, got.clamped);
               end
            end
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_en = 1'b0;
   logic [bsc_pkg::IDX_W-1:0]     csr_index = bsc_pkg::CSR_SENS_C1;
   cal_word_type                  csr_wdata = '0;
   bit                            req_idle_on = 1'b0;
   bit                            rsp_stall_on = 1'b0;
   int unsigned                   cycle_count = 0;
   compensation_scoreboard        sb;

   bsc_req_if req_if ();
   bsc_rsp_if rsp_if ();

   baro_sensor_compensation u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_request(req_if.raw_press, req_if.raw_temp);
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(bsc_pkg::result_type'{
                                 temp_centideg: rsp_if.temp_centideg,
                                 press_centimbar: rsp_if.press_centimbar,
                                 clamped: rsp_if.clamped});
      end
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // response backpressure
   initial begin
      int unsigned gap;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_on && $urandom_range(0, 3) == 0) begin
            gap = idle_len();
            rsp_if.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // raw temperature word whose first-order temperature lands on target
   function automatic raw_word_type raw_temp_for(bsc_pkg::cal_type c, int target);
      longint span, mag, coeff, raw;
      coeff = longint'(c.temp_coeff_c6);
      if (coeff == 0) coeff = 1;
      span = longint'(target) - bsc_pkg::TEMP_BASE;
      mag = (span < 0) ? -span : span;
      mag = (mag * (longint'(1) << bsc_pkg::SH_TEMP) + coeff - 1) / coeff;
      raw = longint'(c.reference_temp_c5) * 256 + ((span < 0) ? -mag : mag);
      if (raw < 0) raw = 0;
      else if (raw > longint'(RAW_MAX)) raw = longint'(RAW_MAX);
      return raw[bsc_pkg::RAW_W-1:0];
   endfunction

   function automatic bsc_pkg::cal_type random_cal(int phase);
      bsc_pkg::cal_type c;
      c = bsc_pkg::cal_type'({$urandom(), $urandom(), $urandom()});
      case (phase)
         0: c = CAL_TYPICAL;
         1: c = CAL_ONES;
         2: c = CAL_ZERO;
         3, 5: begin
            c = CAL_TYPICAL;
            for (int i = 0; i < 6; i++)
               c[bsc_pkg::CAL_W*i +: bsc_pkg::CAL_W] = c[bsc_pkg::CAL_W*i +: bsc_pkg::CAL_W]
                  + cal_word_type'($urandom_range(0, 8000)) - 16'd4000;
         end
         6: begin
            c.reference_temp_c5 = '0;
            c.temp_coeff_c6 = '1;
         end
         7: begin
            c.reference_temp_c5 = '1;
            c.temp_coeff_c6 = 16'd1;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic write_reg(logic [bsc_pkg::IDX_W-1:0] idx, cal_word_type value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.note_write(idx, value);
   endtask

   // spare indexes are written too; they must not disturb the calibration
   task automatic write_calibration(bsc_pkg::cal_type c);
      write_reg(CSR_SPARE_6, cal_word_type'($urandom()));
      write_reg(bsc_pkg::CSR_SENS_C1, c.sensitivity_c1);
      write_reg(bsc_pkg::CSR_OFFSET_C2, c.offset_c2);
      write_reg(bsc_pkg::CSR_SENS_TEMPCO_C3, c.sens_tempco_c3);
      write_reg(bsc_pkg::CSR_OFF_TEMPCO_C4, c.offset_tempco_c4);
      write_reg(bsc_pkg::CSR_REF_TEMP_C5, c.reference_temp_c5);
      write_reg(bsc_pkg::CSR_TEMP_COEFF_C6, c.temp_coeff_c6);
      write_reg(CSR_SPARE_7, cal_word_type'($urandom()));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_conversion(raw_word_type press_raw, raw_word_type temp_raw);
      int unsigned gap;
      gap = (req_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.raw_press <= press_raw;
      req_if.raw_temp <= temp_raw;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_random(bsc_pkg::cal_type c);
      raw_word_type press_raw, temp_raw;
      int           target;
      if ($urandom_range(0, 99) < 65 && c.temp_coeff_c6 != 0) begin
         target = int'($urandom_range(0, 13500)) - 4500;
         temp_raw = raw_temp_for(c, target);
      end else begin
         temp_raw = raw_word_type'($urandom());
      end
      if ($urandom_range(0, 1) == 1)
         press_raw = raw_word_type'($urandom_range(3500000, 10500000));
      else
         press_raw = raw_word_type'($urandom());
      send_conversion(press_raw, temp_raw);
   endtask

   task automatic finish_phase();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      bsc_pkg::cal_type c;
      sb = new();
      req_if.valid = 1'b0;
      req_if.raw_press = '0;
      req_if.raw_temp = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // calibration straight out of reset
      req_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
      send_conversion('0, '0);
      send_conversion(RAW_MAX, RAW_MAX);
      send_conversion(DS_PRESS, DS_TEMP);
      finish_phase();

      c = CAL_TYPICAL;
      write_calibration(c);
      send_conversion(DS_PRESS, DS_TEMP);
      send_conversion('0, RAW_MAX);
      send_conversion(RAW_MAX, '0);
      send_conversion(24'hAAAAAA, 24'h555555);
      send_conversion(24'h555555, 24'hAAAAAA);
      send_conversion(DS_PRESS, raw_temp_for(c, bsc_pkg::TEMP_BASE));
      send_conversion(DS_PRESS, raw_temp_for(c, bsc_pkg::TEMP_BASE - 1));
      send_conversion(DS_PRESS, raw_temp_for(c, bsc_pkg::TEMP_BASE - bsc_pkg::COLD_SHIFT));
      send_conversion(DS_PRESS,
                      raw_temp_for(c, bsc_pkg::TEMP_BASE - bsc_pkg::COLD_SHIFT - 1));
      send_conversion(DS_PRESS, raw_temp_for(c, bsc_pkg::TEMP_MIN));
      send_conversion(DS_PRESS, raw_temp_for(c, bsc_pkg::TEMP_MAX));
      send_conversion(DS_PRESS, raw_temp_for(c, bsc_pkg::TEMP_MAX + 100));
      send_conversion(RAW_MAX, raw_temp_for(c, bsc_pkg::TEMP_BASE));
      send_conversion('0, raw_temp_for(c, bsc_pkg::TEMP_BASE));
      send_conversion(24'd3900000, raw_temp_for(c, -1000));
      finish_phase();

      write_calibration(CAL_ONES);
      send_conversion('0, '0);
      send_conversion(RAW_MAX, RAW_MAX);
      send_conversion(RAW_MAX, '0);
      send_conversion('0, RAW_MAX);
      finish_phase();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         req_idle_on = (p % 3 == 0);
         rsp_stall_on = (p % 3 != 1);
         c = random_cal(p);
         write_calibration(c);
         repeat (ITEMS_PER_PHASE) send_random(c);
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
design/bsc_pkg.sv
design/bsc_req_if.sv
design/bsc_rsp_if.sv
design/bsc_pipe.sv
design/baro_sensor_compensation.sv
sim/baro_sensor_compensation_test.sv
